@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk and switched off while rst_n is low.
`define BFA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int REQ_W     = 13;
    localparam int ADDR_W    = 12;
    localparam int CFG_W     = 13;
    localparam int TAG_BYTES = 4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef logic [REQ_W-1:0]  req_size_t;
    typedef logic [ADDR_W-1:0] blk_addr_t;

endpackage

@@ rtl/bfa_req_if.sv @@
`timescale 1ns / 1ps

interface bfa_req_if import bfa_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      op;
    req_size_t request_size;
    blk_addr_t block_addr;

    modport source (output valid, output op, output request_size, output block_addr,
                    input ready);
    modport sink   (input valid, input op, input request_size, input block_addr,
                    output ready);
endinterface

@@ rtl/bfa_rsp_if.sv @@
`timescale 1ns / 1ps

interface bfa_rsp_if import bfa_pkg::*; ();
    logic      valid;
    logic      ready;
    blk_addr_t granted_addr;
    logic      status;

    modport source (output valid, output granted_addr, output status, input ready);
    modport sink   (input valid, input granted_addr, input status, output ready);
endinterface

@@ rtl/bfa_ram.sv @@
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/best_fit_boundary_tag_allocator.sv @@
// Allocate: walks the free list at one node per cycle, keeps the best fitting free block and
// splits it when the rest can hold a block; an allocation with no fitting block is refused.
// Free: reads the block and its right neighbour, then writes the merged block and links; a free
// of an offset that starts no allocated block writes nothing, nor does a bad size, offset or empty list.
// One request is in work at a time. After reset, and after every arena_size write, a
// clearing pass over all ARENA_MAX entries rebuilds the arena as one free block, taking no request.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_fit_boundary_tag_allocator import bfa_pkg::*; #(
    parameter int ARENA_MAX    = 4096,
    parameter int HEADER_BYTES = 24
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    bfa_req_if.sink          req,
    bfa_rsp_if.source        rsp
);

    localparam int AW        = $clog2(ARENA_MAX);
    localparam int PW        = $clog2(ARENA_MAX + 1);
    localparam int CW        = ((PW > REQ_W) ? PW : REQ_W) + 1;
    localparam int DATA_SKIP = HEADER_BYTES - TAG_BYTES;
    localparam int ARENA_RST = (ARENA_MAX < 4096) ? ARENA_MAX : 4096;

    typedef logic [PW-1:0] ptr_t;

    localparam ptr_t NIL = PW'(ARENA_MAX);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_ADONE = 4'd4;
    localparam logic [3:0] S_FREAD = 4'd5;
    localparam logic [3:0] S_FRD2  = 4'd6;
    localparam logic [3:0] S_W0    = 4'd7;
    localparam logic [3:0] S_W1    = 4'd8;
    localparam logic [3:0] S_W2    = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    localparam logic [2:0] K_SPLIT  = 3'd0;
    localparam logic [2:0] K_WHOLE  = 3'd1;
    localparam logic [2:0] K_FNONE  = 3'd2;
    localparam logic [2:0] K_FLEFT  = 3'd3;
    localparam logic [2:0] K_FRIGHT = 3'd4;
    localparam logic [2:0] K_FBOTH  = 3'd5;

    // Memory ports. Size entries carry {used, size}; tags carry {free, size}.
    logic          size_we, tag_we, next_we, prev_we;
    logic [AW-1:0] size_wa, tag_wa, next_wa, prev_wa;
    logic [AW-1:0] size_ra, tag_ra, next_ra, prev_ra;
    logic [PW:0]   size_wd, tag_wd, size_rd, tag_rd;
    ptr_t          next_wd, prev_wd, next_rd, prev_rd;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    ptr_t          arena_reg, arena_next;
    ptr_t          head_reg, head_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          op_reg, op_next;
    req_size_t     rsize_reg, rsize_next;
    blk_addr_t     baddr_reg, baddr_next;
    ptr_t          cur_reg, cur_next, last_reg, last_next;
    logic          found_reg, found_next;
    ptr_t          fit_reg, fit_next, fp_reg, fp_next, fn_reg, fn_next;
    ptr_t          best_reg, best_next, need_reg, need_next;
    ptr_t          d_reg, d_next, sd_reg, sd_next, mag_reg, mag_next;
    logic          mleft_reg, mleft_next, rvalid_reg, rvalid_next;
    ptr_t          rs_reg, rs_next, rp_reg, rp_next, rn_reg, rn_next, h_reg, h_next;
    logic [2:0]    kind_reg, kind_next;
    blk_addr_t     res_addr_reg, res_addr_next, rsp_addr_reg, rsp_addr_next;
    logic          res_status_reg, res_status_next, rsp_status_reg, rsp_status_next;

    ptr_t          rest, rsz, fend_best, fend_need, dend, dend_r, ns_r, ns_l, ns_b;
    ptr_t          left, pq, sz, right_sum;
    logic          hit, mright;
    logic [CW-1:0] need_c, addr_c, d_c, cfg_c;

    bfa_ram #(.WIDTH(PW + 1), .DEPTH(ARENA_MAX)) u_size_ram (
        .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
        .raddr(size_ra), .rdata(size_rd)
    );

    bfa_ram #(.WIDTH(PW + 1), .DEPTH(ARENA_MAX)) u_tag_ram (
        .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .raddr(tag_ra), .rdata(tag_rd)
    );

    bfa_ram #(.WIDTH(PW), .DEPTH(ARENA_MAX)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(next_ra), .rdata(next_rd)
    );

    bfa_ram #(.WIDTH(PW), .DEPTH(ARENA_MAX)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(prev_ra), .rdata(prev_rd)
    );

    assign rest      = fit_reg + need_reg;
    assign rsz       = best_reg - need_reg;
    assign fend_best = fit_reg + best_reg - PW'(1);
    assign fend_need = fit_reg + need_reg - PW'(1);
    assign dend      = d_reg + sd_reg - PW'(1);
    assign ns_r      = sd_reg + rs_reg;
    assign dend_r    = d_reg + ns_r - PW'(1);
    assign ns_l      = mag_reg + sd_reg;
    assign ns_b      = ns_l + rs_reg;
    assign left      = d_reg - mag_reg;
    // Previous link of the right neighbour's list successor once the freed block has been pushed on the head.
    assign pq        = (rp_reg == NIL) ? d_reg : rp_reg;

    assign sz        = size_rd[PW-1:0];
    assign hit       = (sz >= need_reg) && (!found_reg || (sz < best_reg));
    assign right_sum = d_reg + size_rd[PW-1:0];
    assign mright    = rvalid_reg && !size_rd[PW];

    assign need_c    = CW'(rsize_reg) + CW'(HEADER_BYTES);
    assign addr_c    = CW'(baddr_reg);
    assign d_c       = addr_c - CW'(DATA_SKIP);
    assign cfg_c     = CW'(cfg_wr_data);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.granted_addr = rsp_addr_reg;
    assign rsp.status       = rsp_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        arena_next      = arena_reg;
        head_next       = head_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        rsize_next      = rsize_reg;
        baddr_next      = baddr_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        found_next      = found_reg;
        fit_next        = fit_reg;
        fp_next         = fp_reg;
        fn_next         = fn_reg;
        best_next       = best_reg;
        need_next       = need_reg;
        d_next          = d_reg;
        sd_next         = sd_reg;
        mag_next        = mag_reg;
        mleft_next      = mleft_reg;
        rvalid_next     = rvalid_reg;
        rs_next         = rs_reg;
        rp_next         = rp_reg;
        rn_next         = rn_reg;
        h_next          = h_reg;
        kind_next       = kind_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;

        size_we = 1'b0;  size_wa = '0;  size_wd = '0;  size_ra = '0;
        tag_we  = 1'b0;  tag_wa  = '0;  tag_wd  = '0;  tag_ra  = '0;
        next_we = 1'b0;  next_wa = '0;  next_wd = '0;  next_ra = '0;
        prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;  prev_ra = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                size_we = 1'b1;
                size_wa = cnt_reg;
                size_wd = {1'b0, (cnt_reg == '0) ? arena_reg : ptr_t'(0)};
                if (cnt_reg == '0)
                begin
                    next_we   = 1'b1;
                    next_wd   = NIL;
                    prev_we   = 1'b1;
                    prev_wd   = NIL;
                    tag_we    = 1'b1;
                    tag_wa    = AW'(arena_reg - PW'(1));
                    tag_wd    = {1'b1, arena_reg};
                    head_next = '0;
                end
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(ARENA_MAX - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    rsize_next = req.request_size;
                    baddr_next = req.block_addr;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_addr_next   = '0;
                res_status_next = STATUS_OK;
                if (op_reg == OP_ALLOC)
                begin
                    if ((rsize_reg == '0) ||
                        (CW'(rsize_reg) > (CW'(arena_reg) - CW'(HEADER_BYTES))) ||
                        (head_reg == NIL))
                    begin
                        res_status_next = STATUS_REFUSED;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        size_ra    = head_reg[AW-1:0];
                        next_ra    = head_reg[AW-1:0];
                        cur_next   = head_reg;
                        last_next  = NIL;
                        found_next = 1'b0;
                        need_next  = PW'(need_c);
                        state_next = S_WALK;
                    end
                end
                else if ((addr_c < CW'(DATA_SKIP)) || (d_c >= CW'(arena_reg)))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    d_next     = PW'(d_c);
                    size_ra    = d_c[AW-1:0];
                    tag_ra     = AW'(d_c - CW'(1));
                    state_next = S_FREAD;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    fit_next   = cur_reg;
                    best_next  = sz;
                    fp_next    = last_reg;
                    fn_next    = next_rd;
                end
                last_next = cur_reg;
                if (next_rd == NIL)
                begin
                    state_next = S_ADONE;
                end
                else
                begin
                    size_ra  = next_rd[AW-1:0];
                    next_ra  = next_rd[AW-1:0];
                    cur_next = next_rd;
                end
            end
            S_ADONE:
            begin
                if (!found_reg)
                begin
                    res_status_next = STATUS_REFUSED;
                    state_next      = S_RESP;
                end
                else
                begin
                    // Split only when the remainder can hold a block of its own.
                    if ({1'b0, best_reg} > ({1'b0, need_reg} + (PW + 1)'(HEADER_BYTES)))
                    begin
                        kind_next = K_SPLIT;
                    end
                    else
                    begin
                        kind_next = K_WHOLE;
                    end
                    res_addr_next = ADDR_W'(CW'(fit_reg) + CW'(DATA_SKIP));
                    state_next    = S_W0;
                end
            end
            S_FREAD:
            begin
                if (!size_rd[PW])
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    sd_next     = size_rd[PW-1:0];
                    mag_next    = tag_rd[PW-1:0];
                    mleft_next  = (d_reg != '0) && tag_rd[PW];
                    rvalid_next = right_sum < arena_reg;
                    size_ra     = right_sum[AW-1:0];
                    next_ra     = right_sum[AW-1:0];
                    prev_ra     = right_sum[AW-1:0];
                    state_next  = S_FRD2;
                end
            end
            S_FRD2:
            begin
                rs_next = size_rd[PW-1:0];
                rp_next = prev_rd;
                rn_next = next_rd;
                h_next  = head_reg;
                if (mleft_reg && mright)
                begin
                    kind_next = K_FBOTH;
                end
                else if (mleft_reg)
                begin
                    kind_next = K_FLEFT;
                end
                else if (mright)
                begin
                    kind_next = K_FRIGHT;
                end
                else
                begin
                    kind_next = K_FNONE;
                end
                state_next = S_W0;
            end
            S_W0:
            begin
                size_we    = 1'b1;
                tag_we     = 1'b1;
                state_next = S_W1;
                case (kind_reg)
                    K_SPLIT:
                    begin
                        size_wa = rest[AW-1:0];
                        size_wd = {1'b0, rsz};
                        next_we = 1'b1;
                        next_wa = rest[AW-1:0];
                        next_wd = fn_reg;
                        prev_we = 1'b1;
                        prev_wa = rest[AW-1:0];
                        prev_wd = fp_reg;
                        tag_wa  = fend_best[AW-1:0];
                        tag_wd  = {1'b1, rsz};
                    end
                    K_WHOLE:
                    begin
                        size_wa = fit_reg[AW-1:0];
                        size_wd = {1'b1, best_reg};
                        tag_wa  = fend_best[AW-1:0];
                        tag_wd  = {1'b0, best_reg};
                        if (fp_reg != NIL)
                        begin
                            next_we = 1'b1;
                            next_wa = fp_reg[AW-1:0];
                            next_wd = fn_reg;
                        end
                        else
                        begin
                            head_next = fn_reg;
                        end
                        if (fn_reg != NIL)
                        begin
                            prev_we = 1'b1;
                            prev_wa = fn_reg[AW-1:0];
                            prev_wd = fp_reg;
                        end
                        state_next = S_RESP;
                    end
                    K_FNONE:
                    begin
                        size_wa   = d_reg[AW-1:0];
                        size_wd   = {1'b0, sd_reg};
                        next_we   = 1'b1;
                        next_wa   = d_reg[AW-1:0];
                        next_wd   = h_reg;
                        prev_we   = 1'b1;
                        prev_wa   = d_reg[AW-1:0];
                        prev_wd   = NIL;
                        tag_wa    = dend[AW-1:0];
                        tag_wd    = {1'b1, sd_reg};
                        head_next = d_reg;
                    end
                    K_FLEFT:
                    begin
                        size_wa = left[AW-1:0];
                        size_wd = {1'b0, ns_l};
                        tag_wa  = dend[AW-1:0];
                        tag_wd  = {1'b1, ns_l};
                    end
                    K_FRIGHT:
                    begin
                        size_wa   = d_reg[AW-1:0];
                        size_wd   = {1'b0, ns_r};
                        next_we   = 1'b1;
                        next_wa   = d_reg[AW-1:0];
                        next_wd   = (rp_reg == NIL) ? rn_reg : h_reg;
                        prev_we   = 1'b1;
                        prev_wa   = d_reg[AW-1:0];
                        prev_wd   = NIL;
                        tag_wa    = dend_r[AW-1:0];
                        tag_wd    = {1'b1, ns_r};
                        head_next = d_reg;
                    end
                    default:
                    begin
                        size_wa = left[AW-1:0];
                        size_wd = {1'b0, ns_b};
                        tag_wa  = dend_r[AW-1:0];
                        tag_wd  = {1'b1, ns_b};
                        if (rp_reg != NIL)
                        begin
                            next_we = 1'b1;
                            next_wa = rp_reg[AW-1:0];
                            next_wd = rn_reg;
                        end
                        else
                        begin
                            head_next = rn_reg;
                        end
                        if (rn_reg != NIL)
                        begin
                            prev_we = 1'b1;
                            prev_wa = rn_reg[AW-1:0];
                            prev_wd = rp_reg;
                        end
                    end
                endcase
            end
            S_W1:
            begin
                state_next = S_RESP;
                case (kind_reg)
                    K_SPLIT:
                    begin
                        size_we = 1'b1;
                        size_wa = fit_reg[AW-1:0];
                        size_wd = {1'b1, need_reg};
                        tag_we  = 1'b1;
                        tag_wa  = fend_need[AW-1:0];
                        tag_wd  = {1'b0, need_reg};
                        if (fp_reg != NIL)
                        begin
                            next_we = 1'b1;
                            next_wa = fp_reg[AW-1:0];
                            next_wd = rest;
                        end
                        else
                        begin
                            head_next = rest;
                        end
                        if (fn_reg != NIL)
                        begin
                            prev_we = 1'b1;
                            prev_wa = fn_reg[AW-1:0];
                            prev_wd = rest;
                        end
                    end
                    K_FNONE:
                    begin
                        if (h_reg != NIL)
                        begin
                            prev_we = 1'b1;
                            prev_wa = h_reg[AW-1:0];
                            prev_wd = d_reg;
                        end
                    end
                    K_FRIGHT:
                    begin
                        if (rp_reg != NIL)
                        begin
                            next_we = 1'b1;
                            next_wa = rp_reg[AW-1:0];
                            next_wd = rn_reg;
                        end
                        if (h_reg != NIL)
                        begin
                            prev_we = 1'b1;
                            prev_wa = h_reg[AW-1:0];
                            prev_wd = d_reg;
                        end
                        state_next = S_W2;
                    end
                    default:
                    begin
                        // The freed block's start becomes interior; drop its used mark.
                        size_we = 1'b1;
                        size_wa = d_reg[AW-1:0];
                        size_wd = {1'b0, sd_reg};
                    end
                endcase
            end
            S_W2:
            begin
                if (rn_reg != NIL)
                begin
                    prev_we = 1'b1;
                    prev_wa = rn_reg[AW-1:0];
                    prev_wd = pq;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase

        if (cfg_wr_en)
        begin
            if (cfg_c > CW'(ARENA_MAX))
            begin
                arena_next = NIL;
            end
            else if (cfg_c < CW'(HEADER_BYTES + 1))
            begin
                arena_next = PW'(HEADER_BYTES + 1);
            end
            else
            begin
                arena_next = PW'(cfg_c);
            end
            cnt_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            arena_reg     <= PW'(ARENA_RST);
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            arena_reg     <= arena_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rsize_reg      <= rsize_next;
        baddr_reg      <= baddr_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        found_reg      <= found_next;
        fit_reg        <= fit_next;
        fp_reg         <= fp_next;
        fn_reg         <= fn_next;
        best_reg       <= best_next;
        need_reg       <= need_next;
        d_reg          <= d_next;
        sd_reg         <= sd_next;
        mag_reg        <= mag_next;
        mleft_reg      <= mleft_next;
        rvalid_reg     <= rvalid_next;
        rs_reg         <= rs_next;
        rp_reg         <= rp_next;
        rn_reg         <= rn_next;
        h_reg          <= h_next;
        kind_reg       <= kind_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    `BFA_ASSERT_IMPL(a_head_in_arena, state_reg != S_CLEAR, (head_reg == NIL) || (head_reg < arena_reg), "free list head lies outside the arena")
    `BFA_ASSERT_IMPL(a_walk_not_nil, state_reg == S_WALK, cur_reg != NIL, "free list walk reached a null node")
    `BFA_ASSERT_IMPL(a_refused_zero, rsp_valid_reg && (rsp_status_reg == STATUS_REFUSED), rsp_addr_reg == '0, "refused request carries an address")
    `BFA_ASSERT_NEXT(a_accept_starts, req.valid && req.ready && !cfg_wr_en, state_reg == S_START, "accepted request did not start")

endmodule
